[hw/rtl/lbvs_pkg.sv]
// ----------------------------------------------------------------------------
// lbvs_pkg: shared definitions for the linear blend vertex skinning block
// Widths of the fixed-point datapath, divider step function and the
// reciprocal used to split a palette address into bone and matrix word.
// ----------------------------------------------------------------------------
package lbvs_pkg;

  // Palette geometry and field layout.
  localparam int MAX_BONES_DEF = 64;
  localparam int NUM_INFL      = 4;
  localparam int NUM_AXES      = 3;
  localparam int MAT_WORDS     = 12;
  localparam int MAT_COLS      = 4;
  localparam int BONE_IDX_W    = 6;
  localparam int WEIGHT_W      = 8;
  localparam int ADDR_W        = 10;
  localparam int WORD_W        = 32;

  // Address / 12 as a multiply by 683 and a shift by 13 (exact for 10 bits).
  localparam int RECIP12    = 683;
  localparam int RECIP12_SH = 13;

  // Datapath widths.
  localparam int PROD_W  = 48;          // rounded Q16.16 matrix product
  localparam int XFORM_W = 50;          // one bone transform of one axis
  localparam int WPROD_W = XFORM_W + 9; // weight times transform
  localparam int ACC_W   = WPROD_W + 2; // sum over four influences
  localparam int MAG_W   = ACC_W;       // magnitude plus rounding half
  localparam int SUM_W   = 10;          // sum of four 8-bit weights
  localparam int REM_W   = SUM_W + 1;   // divider partial remainder

  // Divider: a 32-bit quotient, eight bits per stage.
  localparam int DIV_STEPS  = 8;
  localparam int DIV_STAGES = 4;
  localparam int QUOT_W     = DIV_STEPS * DIV_STAGES;
  localparam int HI_W       = MAG_W - QUOT_W;

  // Result channels: three position axes, then three normal axes.
  localparam int NUM_CH = 2 * NUM_AXES;

  localparam logic signed [WORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [REM_W-1:0]     rem;
    logic [DIV_STEPS-1:0] q;
  } div_part_t;

  // Eight restoring division steps on a narrow remainder.
  function automatic div_part_t div_step8(logic [REM_W-1:0] rem_in,
                                          logic [DIV_STEPS-1:0] bits,
                                          logic [SUM_W-1:0] dvs);
    div_part_t        res;
    logic [REM_W-1:0] r;
    r = rem_in;
    res.q = '0;
    for (int i = DIV_STEPS - 1; i >= 0; i--) begin
      r = {r[REM_W-2:0], bits[i]};
      if (r >= {1'b0, dvs}) begin
        r = r - {1'b0, dvs};
        res.q[i] = 1'b1;
      end
    end
    res.rem = r;
    return res;
  endfunction

endpackage

[hw/rtl/linear_blend_vertex_skinning.sv]
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning: four-influence vertex skinning engine
// Blends up to four 3x4 bone transforms of a vertex position and normal in
// signed Q16.16, with saturation and a fault flag.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel (item_valid / item_stall) carries one beat per item.
//   A beat with func = 0 writes one palette word and gives no result; a beat
//   with func = 1 skins one vertex and gives exactly one result beat on the
//   result channel (result_valid / result_stall).
//   An accepted skin beat leaves the last pipeline stage as its result beat, and
//   one beat is taken every cycle while the result side does not stall.
//   The rate comes from a 12-stage pipeline: a registered palette read, the
//   matrix multiply, the row sums, the weight multiply, the influence sum,
//   rounding prep, and a divider that resolves eight quotient bits per stage.
//   The palette is replicated once per influence and once per matrix word,
//   so all 48 words of a vertex are read in the same cycle.
//   A palette write takes effect for every skin beat accepted after it.
//   Reset clears the pipeline valid bits only; the palette is undefined until
//   written. While the receiver stalls a waiting result, the whole pipeline
//   holds and item_stall is raised.
module linear_blend_vertex_skinning #(
  parameter int MAX_BONES = lbvs_pkg::MAX_BONES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic                                func,
  input  logic [lbvs_pkg::ADDR_W-1:0]         palette_word,
  input  logic signed [lbvs_pkg::WORD_W-1:0]  palette_value,
  input  logic signed [lbvs_pkg::WORD_W-1:0]  pos_x,
  input  logic signed [lbvs_pkg::WORD_W-1:0]  pos_y,
  input  logic signed [lbvs_pkg::WORD_W-1:0]  pos_z,
  input  logic signed [lbvs_pkg::WORD_W-1:0]  nrm_x,
  input  logic signed [lbvs_pkg::WORD_W-1:0]  nrm_y,
  input  logic signed [lbvs_pkg::WORD_W-1:0]  nrm_z,
  input  logic [23:0]                         bone_set,
  input  logic [31:0]                         weight_set,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [lbvs_pkg::WORD_W-1:0]  skinned_pos_x,
  output logic signed [lbvs_pkg::WORD_W-1:0]  skinned_pos_y,
  output logic signed [lbvs_pkg::WORD_W-1:0]  skinned_pos_z,
  output logic signed [lbvs_pkg::WORD_W-1:0]  skinned_nrm_x,
  output logic signed [lbvs_pkg::WORD_W-1:0]  skinned_nrm_y,
  output logic signed [lbvs_pkg::WORD_W-1:0]  skinned_nrm_z,
  output logic                                fault
);
  import lbvs_pkg::*;

  localparam int BW        = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  localparam int PAL_WORDS = MAX_BONES * MAT_WORDS;
  localparam int DEPTH     = 8 + DIV_STAGES;

  // Global advance: every stage moves unless a finished result is stalled.
  logic adv;
  logic skin_acc;
  logic wr_en;
  logic [DEPTH:1] vld;

  assign adv        = !(result_valid && result_stall);
  assign item_stall = !adv;
  assign skin_acc   = item_valid && adv && func;
  assign wr_en      = item_valid && adv && !func
                      && ({2'b00, palette_word} < 12'(PAL_WORDS));
  assign result_valid = vld[DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-1:1], skin_acc};
    end
  end

  // Palette address split into bone and matrix word.
  logic [19:0]          wr_mul;
  logic [6:0]           wr_bone7;
  logic [7:0]           wr_bone8;
  logic [ADDR_W-1:0]    wr_word_full;
  logic [3:0]           wr_word;

  assign wr_mul       = 20'(palette_word) * 20'(RECIP12);
  assign wr_bone7     = wr_mul[RECIP12_SH+6:RECIP12_SH];
  assign wr_bone8     = {1'b0, wr_bone7};
  assign wr_word_full = palette_word - (ADDR_W'(wr_bone7) * ADDR_W'(MAT_WORDS));
  assign wr_word      = wr_word_full[3:0];

  // Read index and in-range flag for each influence.
  logic [7:0]          rd_bone8 [NUM_INFL];
  logic [BW-1:0]       rd_idx   [NUM_INFL];
  logic                rd_ok    [NUM_INFL];
  logic [WEIGHT_W-1:0] wt_in    [NUM_INFL];

  always_comb begin
    for (int k = 0; k < NUM_INFL; k++) begin
      rd_bone8[k] = 8'(bone_set[BONE_IDX_W*k +: BONE_IDX_W]);
      rd_idx[k]   = rd_bone8[k][BW-1:0];
      rd_ok[k]    = ({1'b0, rd_bone8[k]} < 9'(MAX_BONES));
      wt_in[k]    = weight_set[WEIGHT_W*k +: WEIGHT_W];
    end
  end

  // Stage 1: palette banks, one per influence and matrix word.
  logic signed [WORD_W-1:0] m1 [NUM_INFL][MAT_WORDS];

  for (genvar gk = 0; gk < NUM_INFL; gk++) begin : g_infl
    for (genvar gj = 0; gj < MAT_WORDS; gj++) begin : g_word
      logic signed [WORD_W-1:0] mem [MAX_BONES];

      always_ff @(posedge clk) begin
        if (wr_en && (wr_word == 4'(gj))) begin
          mem[wr_bone8[BW-1:0]] <= palette_value;
        end
        if (adv) begin
          m1[gk][gj] <= mem[rd_idx[gk]];
        end
      end
    end
  end

  logic                     use1 [NUM_INFL];
  logic [WEIGHT_W-1:0]      w1   [NUM_INFL];
  logic signed [WORD_W-1:0] p1   [NUM_AXES];
  logic signed [WORD_W-1:0] n1   [NUM_AXES];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NUM_INFL; k++) begin
        use1[k] <= rd_ok[k] && (wt_in[k] != '0);
        w1[k]   <= wt_in[k];
      end
      p1[0] <= pos_x;
      p1[1] <= pos_y;
      p1[2] <= pos_z;
      n1[0] <= nrm_x;
      n1[1] <= nrm_y;
      n1[2] <= nrm_z;
    end
  end

  // Stage 2: matrix products, rounded to Q16.16.
  logic signed [PROD_W-1:0] pr2_next [NUM_INFL][NUM_AXES][NUM_AXES];
  logic signed [PROD_W-1:0] nr2_next [NUM_INFL][NUM_AXES][NUM_AXES];
  logic signed [WORD_W-1:0] tr2_next [NUM_INFL][NUM_AXES];
  logic signed [PROD_W-1:0] pr2      [NUM_INFL][NUM_AXES][NUM_AXES];
  logic signed [PROD_W-1:0] nr2      [NUM_INFL][NUM_AXES][NUM_AXES];
  logic signed [WORD_W-1:0] tr2      [NUM_INFL][NUM_AXES];
  logic [WEIGHT_W-1:0]      w2       [NUM_INFL];

  always_comb begin
    logic signed [WORD_W-1:0]   mv;
    logic signed [2*WORD_W-1:0] pp;
    logic signed [2*WORD_W-1:0] pn;
    for (int k = 0; k < NUM_INFL; k++) begin
      for (int r = 0; r < NUM_AXES; r++) begin
        tr2_next[k][r] = use1[k] ? m1[k][r*MAT_COLS+3] : '0;
        for (int c = 0; c < NUM_AXES; c++) begin
          mv = use1[k] ? m1[k][r*MAT_COLS+c] : '0;
          pp = mv * p1[c] + 64'sd32768;
          pn = mv * n1[c] + 64'sd32768;
          pr2_next[k][r][c] = pp[2*WORD_W-1:16];
          nr2_next[k][r][c] = pn[2*WORD_W-1:16];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pr2 <= pr2_next;
      nr2 <= nr2_next;
      tr2 <= tr2_next;
      w2  <= w1;
    end
  end

  // Stage 3: the transformed axes of each influence, and the weight sum.
  logic signed [XFORM_W-1:0] tp3_next [NUM_INFL][NUM_AXES];
  logic signed [XFORM_W-1:0] tn3_next [NUM_INFL][NUM_AXES];
  logic [SUM_W-1:0]          sum3_next;
  logic signed [XFORM_W-1:0] tp3 [NUM_INFL][NUM_AXES];
  logic signed [XFORM_W-1:0] tn3 [NUM_INFL][NUM_AXES];
  logic [WEIGHT_W-1:0]       w3  [NUM_INFL];
  logic [SUM_W-1:0]          sum3;

  always_comb begin
    sum3_next = '0;
    for (int k = 0; k < NUM_INFL; k++) begin
      sum3_next = sum3_next + SUM_W'(w2[k]);
      for (int r = 0; r < NUM_AXES; r++) begin
        tp3_next[k][r] = XFORM_W'(tr2[k][r]) + XFORM_W'(pr2[k][r][0])
                         + XFORM_W'(pr2[k][r][1]) + XFORM_W'(pr2[k][r][2]);
        tn3_next[k][r] = XFORM_W'(nr2[k][r][0]) + XFORM_W'(nr2[k][r][1])
                         + XFORM_W'(nr2[k][r][2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tp3  <= tp3_next;
      tn3  <= tn3_next;
      w3   <= w2;
      sum3 <= sum3_next;
    end
  end

  // Stage 4: weight times transform.
  logic signed [WPROD_W-1:0] wp4 [NUM_INFL][NUM_AXES];
  logic signed [WPROD_W-1:0] wn4 [NUM_INFL][NUM_AXES];
  logic [SUM_W-1:0]          sum4;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NUM_INFL; k++) begin
        for (int r = 0; r < NUM_AXES; r++) begin
          wp4[k][r] <= $signed({1'b0, w3[k]}) * tp3[k][r];
          wn4[k][r] <= $signed({1'b0, w3[k]}) * tn3[k][r];
        end
      end
      sum4 <= sum3;
    end
  end

  // Stage 5: blend numerators over all influences.
  logic signed [ACC_W-1:0] acc5_next [NUM_CH];
  logic signed [ACC_W-1:0] acc5      [NUM_CH];
  logic [SUM_W-1:0]        sum5;

  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      acc5_next[r]          = '0;
      acc5_next[NUM_AXES+r] = '0;
      for (int k = 0; k < NUM_INFL; k++) begin
        acc5_next[r]          = acc5_next[r] + ACC_W'(wp4[k][r]);
        acc5_next[NUM_AXES+r] = acc5_next[NUM_AXES+r] + ACC_W'(wn4[k][r]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc5 <= acc5_next;
      sum5 <= sum4;
    end
  end

  // Stage 6: magnitude plus half the divisor, rounding ties away from zero.
  logic [MAG_W-1:0] mag6 [NUM_CH];
  logic             neg6 [NUM_CH];
  logic [SUM_W-1:0] sum6;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        neg6[ch] <= acc5[ch][ACC_W-1];
        mag6[ch] <= (acc5[ch][ACC_W-1] ? (~acc5[ch] + MAG_W'(1)) : acc5[ch])
                    + MAG_W'(sum5 >> 1);
      end
      sum6 <= sum5;
    end
  end

  // Divider entry: saturation test on the high part, then the first remainder.
  logic [REM_W-1:0]  dv_rem [DIV_STAGES+1][NUM_CH];
  logic [QUOT_W-1:0] dv_q   [DIV_STAGES+1][NUM_CH];
  logic [QUOT_W-1:0] dv_lo  [DIV_STAGES+1][NUM_CH];
  logic              dv_neg [DIV_STAGES+1][NUM_CH];
  logic              dv_sat [DIV_STAGES+1][NUM_CH];
  logic [SUM_W-1:0]  dv_sum [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        dv_sat[0][ch] <= (mag6[ch][MAG_W-1:QUOT_W] >= HI_W'(sum6));
        dv_rem[0][ch] <= mag6[ch][QUOT_W+REM_W-1:QUOT_W];
        dv_lo[0][ch]  <= mag6[ch][QUOT_W-1:0];
        dv_q[0][ch]   <= '0;
        dv_neg[0][ch] <= neg6[ch];
      end
      dv_sum[0] <= sum6;
    end
  end

  // Divider stages: eight quotient bits each.
  div_part_t dv_part [DIV_STAGES][NUM_CH];

  for (genvar gd = 1; gd <= DIV_STAGES; gd++) begin : g_div
    always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        dv_part[gd-1][ch] = div_step8(dv_rem[gd-1][ch],
          dv_lo[gd-1][ch][QUOT_W-1-(gd-1)*DIV_STEPS -: DIV_STEPS], dv_sum[gd-1]);
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
          dv_rem[gd][ch] <= dv_part[gd-1][ch].rem;
          dv_q[gd][ch]   <= {dv_q[gd-1][ch][QUOT_W-DIV_STEPS-1:0],
                             dv_part[gd-1][ch].q};
          dv_lo[gd][ch]  <= dv_lo[gd-1][ch];
          dv_neg[gd][ch] <= dv_neg[gd-1][ch];
          dv_sat[gd][ch] <= dv_sat[gd-1][ch];
        end
        dv_sum[gd] <= dv_sum[gd-1];
      end
    end
  end

  // Output stage: sign, saturation and the fault flag.
  logic signed [WORD_W-1:0] res_next [NUM_CH];
  logic                     fault_next;
  logic signed [WORD_W-1:0] res      [NUM_CH];

  always_comb begin
    logic [QUOT_W-1:0] qv;
    fault_next = 1'b0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      qv = dv_q[DIV_STAGES][ch];
      if (dv_sum[DIV_STAGES] == '0) begin
        res_next[ch] = '0;
      end else if (!dv_neg[DIV_STAGES][ch]) begin
        if (dv_sat[DIV_STAGES][ch] || qv[QUOT_W-1]) begin
          res_next[ch] = SAT_MAX;
          fault_next   = 1'b1;
        end else begin
          res_next[ch] = $signed(qv);
        end
      end else begin
        if (dv_sat[DIV_STAGES][ch] || (qv > 32'h8000_0000)) begin
          res_next[ch] = SAT_MIN;
          fault_next   = 1'b1;
        end else begin
          res_next[ch] = $signed(~qv + 32'd1);
        end
      end
    end
    if (dv_sum[DIV_STAGES] == '0) begin
      fault_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res   <= res_next;
      fault <= fault_next;
    end
  end

  assign skinned_pos_x = res[0];
  assign skinned_pos_y = res[1];
  assign skinned_pos_z = res[2];
  assign skinned_nrm_x = res[3];
  assign skinned_nrm_y = res[4];
  assign skinned_nrm_z = res[5];

`ifndef NO_ASSERTIONS
  // A palette write beat never starts a result.
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && !func) |=> !vld[1])
    else $error("palette write entered the skin pipeline");

  // A stalled result freezes the pipeline valid bits.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> $stable(vld))
    else $error("pipeline moved while the result was stalled");

  // A zero weight sum always reports a fault.
  a_zero_sum_fault: assert property (@(posedge clk) disable iff (rst)
    (vld[DEPTH-1] && adv && (dv_sum[DIV_STAGES] == '0)) |=> fault)
    else $error("zero weight sum without fault");
`endif

endmodule
